// ===== sv/acl_pkg.sv =====
// Shared types and constants for the masked address ACL match block.
package acl_pkg;

    localparam int DEFAULT_TABLE_DEPTH = 16;

    // Stream payload widths, padded to whole bytes
    localparam int IN_TDATA_W  = 264;
    localparam int OUT_TDATA_W = 8;

    // Item kinds carried in s_tuser
    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_CHECK = 1'b1;

    // Upper word of the low half of an IPv4-mapped IPv6 address
    localparam logic [31:0] MAPPED_PREFIX = 32'h0000_FFFF;

    // Front queue depth
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    // One classified item as it travels from the front to the back part
    typedef struct packed {
        logic        is_check;
        logic        q4;
        logic [3:0]  entry_index;
        logic        entry_is_ipv6;
        logic        entry_enable;
        logic [63:0] value_hi;
        logic [63:0] value_lo;
        logic [63:0] mask_hi;
        logic [63:0] mask_lo;
    } acl_item_t;

    // One stored table entry
    typedef struct packed {
        logic        is_ipv6;
        logic [63:0] addr_hi;
        logic [63:0] addr_lo;
        logic [63:0] mask_hi;
        logic [63:0] mask_lo;
    } acl_entry_t;

    // One result item
    typedef struct packed {
        logic       query_was_ipv4;
        logic [3:0] match_index;
        logic       authorized;
    } acl_result_t;

endpackage

// ===== sv/acl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module acl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/acl_front.sv =====
// Front part: accepts input transfers, classifies them and queues them for the back part.
module acl_front (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [acl_pkg::IN_TDATA_W-1:0]     s_tdata,
    input  logic                               s_tuser,
    output logic                               item_valid,
    output acl_pkg::acl_item_t                 item,
    input  logic                               pop
);

    acl_pkg::acl_item_t          in_item;
    acl_pkg::acl_item_t          queue_reg [acl_pkg::QUEUE_DEPTH];
    logic [acl_pkg::QPTR_W-1:0]  wr_ptr_reg;
    logic [acl_pkg::QPTR_W-1:0]  wr_ptr_next;
    logic [acl_pkg::QPTR_W-1:0]  rd_ptr_reg;
    logic [acl_pkg::QPTR_W-1:0]  rd_ptr_next;
    logic [acl_pkg::QCNT_W-1:0]  count_reg;
    logic [acl_pkg::QCNT_W-1:0]  count_next;
    logic                        push;
    logic                        do_pop;

    // Unpack the transfer and flag IPv4-mapped queries
    always_comb
    begin
        in_item.is_check      = (s_tuser == acl_pkg::MODE_CHECK);
        in_item.entry_index   = s_tdata[3:0];
        in_item.entry_is_ipv6 = s_tdata[4];
        in_item.entry_enable  = s_tdata[5];
        in_item.value_hi      = s_tdata[69:6];
        in_item.value_lo      = s_tdata[133:70];
        in_item.mask_hi       = s_tdata[197:134];
        in_item.mask_lo       = s_tdata[261:198];
        in_item.q4            = (s_tdata[69:6] == 64'd0) &&
                                (s_tdata[133:102] == acl_pkg::MAPPED_PREFIX);
    end

    assign s_tready   = (count_reg != acl_pkg::QCNT_W'(acl_pkg::QUEUE_DEPTH));
    assign push       = s_tvalid && s_tready;
    assign item_valid = (count_reg != '0);
    assign item       = queue_reg[rd_ptr_reg];
    assign do_pop     = pop && item_valid;

    // Advance the queue pointers and fill count
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the accepted item
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

// ===== sv/acl_back.sv =====
// Back part: applies table writes and walks the table one slot per cycle for checks.
module acl_back #(
    parameter int TABLE_DEPTH = acl_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    input  acl_pkg::acl_item_t   item,
    output logic                 pop,
    output logic                 res_valid,
    output acl_pkg::acl_result_t res,
    input  logic                 res_ready
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int EW = $bits(acl_pkg::acl_entry_t);
    localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_DEPTH - 1);
    localparam logic [CW-1:0] CNT_END  = CW'(TABLE_DEPTH);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_WALK = 1'b1;

    logic                 state_reg;
    logic                 state_next;
    logic [CW-1:0]        cnt_reg;
    logic [CW-1:0]        cnt_next;
    logic                 pend_valid_reg;
    logic                 pend_valid_next;
    logic [AW-1:0]        pend_idx_reg;
    logic                 pend_slot_valid_reg;
    logic [63:0]          q_hi_reg;
    logic [63:0]          q_lo_reg;
    logic                 q4_reg;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    acl_pkg::acl_result_t out_res_reg;
    acl_pkg::acl_result_t out_res_next;
    logic                 slot_valid_reg [TABLE_DEPTH];

    logic                 out_free;
    logic                 in_range;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [AW-1:0]        rd_addr;
    logic                 issue;
    logic                 finish;
    logic                 hit;
    logic [EW-1:0]        rd_data;
    acl_pkg::acl_entry_t  wr_entry;
    acl_pkg::acl_entry_t  rd_entry;

    assign out_free = !out_valid_reg || res_ready;
    assign pop      = (state_reg == ST_IDLE) && item_valid && out_free;
    assign in_range = (32'(item.entry_index) < 32'(TABLE_DEPTH));
    assign wr_en    = pop && !item.is_check && in_range;
    assign wr_addr  = AW'(item.entry_index);
    assign rd_addr  = cnt_reg[AW-1:0];
    assign issue    = (state_reg == ST_WALK) && (cnt_reg != CNT_END);

    always_comb
    begin
        wr_entry.is_ipv6 = item.entry_is_ipv6;
        wr_entry.addr_hi = item.value_hi;
        wr_entry.addr_lo = item.value_lo;
        wr_entry.mask_hi = item.mask_hi;
        wr_entry.mask_lo = item.mask_lo;
    end

    acl_ram #(
        .WIDTH (EW),
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_table (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_entry),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    assign rd_entry = acl_pkg::acl_entry_t'(rd_data);

    // Compare the slot read last cycle against the held query
    always_comb
    begin
        if (q4_reg)
        begin
            hit = !rd_entry.is_ipv6 &&
                  (((q_lo_reg[31:0] ^ rd_entry.addr_lo[31:0]) & rd_entry.mask_lo[31:0]) == '0);
        end
        else
        begin
            hit = rd_entry.is_ipv6 &&
                  (((q_hi_reg ^ rd_entry.addr_hi) & rd_entry.mask_hi) == '0) &&
                  (((q_lo_reg ^ rd_entry.addr_lo) & rd_entry.mask_lo) == '0);
        end
        hit = hit && pend_slot_valid_reg;
    end

    assign finish = (state_reg == ST_WALK) && pend_valid_reg &&
                    (hit || (pend_idx_reg == LAST_IDX));

    // Sequence the walk and load the result register
    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        pend_valid_next = issue && !finish;
        out_valid_next  = out_valid_reg && !res_ready;
        out_res_next    = out_res_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (pop)
                begin
                    if (item.is_check)
                    begin
                        state_next = ST_WALK;
                        cnt_next   = '0;
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                        out_res_next   = '0;
                    end
                end
            end
            ST_WALK:
            begin
                if (issue)
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
                if (finish)
                begin
                    state_next                  = ST_IDLE;
                    out_valid_next              = 1'b1;
                    out_res_next.authorized     = hit;
                    out_res_next.match_index    = hit ? 4'(pend_idx_reg) : 4'd0;
                    out_res_next.query_was_ipv4 = q4_reg;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i < TABLE_DEPTH; i++)
            begin
                slot_valid_reg[i] <= 1'b0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            if (wr_en)
            begin
                slot_valid_reg[wr_addr] <= item.entry_enable;
            end
        end
    end

    // Hold the query, track the slot in flight and the result payload
    always_ff @(posedge clk)
    begin
        if (pop && item.is_check)
        begin
            q_hi_reg <= item.value_hi;
            q_lo_reg <= item.value_lo;
            q4_reg   <= item.q4;
        end
        if (issue)
        begin
            pend_idx_reg        <= rd_addr;
            pend_slot_valid_reg <= slot_valid_reg[rd_addr];
        end
        out_res_reg <= out_res_next;
    end

    assign res_valid = out_valid_reg;
    assign res       = out_res_reg;

`ifndef SYNTHESIS
    // The result register stays empty while a walk is running
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK) |-> !out_valid_reg)
        else $error("result register busy during table walk");

    // The walk counter never runs past the table
    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_END)
        else $error("walk counter past table end");

    // A slot compare only happens inside a walk
    assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> (state_reg == ST_WALK))
        else $error("slot compare outside a walk");

    // A write yields an all-zero result on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !item.is_check) |=>
            (out_valid_reg && !out_res_reg.authorized &&
             !out_res_reg.query_was_ipv4 && (out_res_reg.match_index == 4'd0)))
        else $error("write did not yield a zero result");

    // A walk always ends with a result
    assert property (@(posedge clk) disable iff (!rst_n)
        finish |=> (out_valid_reg && (state_reg == ST_IDLE)))
        else $error("walk ended without a result");
`endif

endmodule

// ===== sv/masked_address_acl_match.sv =====
// A write's all-zero result is registered as the write leaves the queue; a check walks the table
// from slot 0, and its result is registered at the lowest matching slot, or after the last slot on no match.
// Throughput: one write per cycle while m_tready is high and no walk runs; a check holds the back part
// until its table walk ends, reading one slot per cycle from the single read port of the table RAM.
// A 2-entry queue lets inputs be accepted while a walk runs or a result waits.
// Reset (rst_n, asynchronous, active low) empties queue and result, and clears all slot valid bits.
module masked_address_acl_match #(
    parameter int TABLE_DEPTH = acl_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // entry_index[3:0], entry_is_ipv6[4], entry_enable[5], value_hi[69:6],
    // value_lo[133:70], mask_hi[197:134], mask_lo[261:198], zero[263:262]
    input  logic [acl_pkg::IN_TDATA_W-1:0]  s_tdata,
    // mode[0]
    input  logic                            s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // authorized[0], match_index[4:1], query_was_ipv4[5], zero[7:6]
    output logic [acl_pkg::OUT_TDATA_W-1:0] m_tdata
);

    logic                 item_valid;
    acl_pkg::acl_item_t   item;
    logic                 pop;
    acl_pkg::acl_result_t res;

    acl_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .item_valid (item_valid),
        .item       (item),
        .pop        (pop)
    );

    acl_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .pop        (pop),
        .res_valid  (m_tvalid),
        .res        (res),
        .res_ready  (m_tready)
    );

    // Pack the result transfer
    assign m_tdata = {2'b00, res.query_was_ipv4, res.match_index, res.authorized};

endmodule
